/* sv/mmpd_pkg.sv */
// mmpd_pkg: shared types and constants for the min/max peak decimator
// used by mmpd_window, min_max_peak_decimator, mmpd_checker and the testbench
package mmpd_pkg;

    // width of the samples_per_peak configuration register
    localparam int unsigned CFG_WIDTH = 16;

    // reset value of samples_per_peak
    localparam logic [CFG_WIDTH-1:0] CFG_RESET = 16'd1;

    // control that travels with one result item from the window logic
    typedef struct packed {
        logic valid;
        logic final_pair;
    } res_ctrl_t;

endpackage

/* sv/mmpd_window.sv */
// mmpd_window: running min/max and fill count of the current window
// depends on mmpd_pkg (CFG_WIDTH, res_ctrl_t)
module mmpd_window #(
    parameter int unsigned SAMPLE_WIDTH = 16,
    parameter int unsigned COUNT_WIDTH  = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [mmpd_pkg::CFG_WIDTH-1:0]     samples_per_peak,
    input  logic                               in_fire,
    input  logic signed [SAMPLE_WIDTH-1:0]     sample,
    input  logic                               end_of_range,
    output mmpd_pkg::res_ctrl_t                res_ctrl,
    output logic signed [SAMPLE_WIDTH-1:0]     peak_min,
    output logic signed [SAMPLE_WIDTH-1:0]     peak_max
);

    localparam int unsigned LW =
        (COUNT_WIDTH > mmpd_pkg::CFG_WIDTH) ? COUNT_WIDTH : mmpd_pkg::CFG_WIDTH;

    logic signed [SAMPLE_WIDTH-1:0] min_reg;
    logic signed [SAMPLE_WIDTH-1:0] min_next;
    logic signed [SAMPLE_WIDTH-1:0] max_reg;
    logic signed [SAMPLE_WIDTH-1:0] max_next;
    logic [COUNT_WIDTH-1:0]         count_reg;
    logic [COUNT_WIDTH-1:0]         count_next;
    logic [COUNT_WIDTH-1:0]         count_inc;
    logic [LW-1:0]                  spp_ext;
    logic [LW-1:0]                  cmax_ext;
    logic [LW-1:0]                  limit;
    logic                           close;

    // window length: zero acts as one, saturate at counter range
    always_comb
    begin
        spp_ext  = LW'(samples_per_peak);
        cmax_ext = LW'({COUNT_WIDTH{1'b1}});
        if (samples_per_peak == '0)
        begin
            limit = LW'(1);
        end
        else if (spp_ext > cmax_ext)
        begin
            limit = cmax_ext;
        end
        else
        begin
            limit = spp_ext;
        end
    end

    always_comb
    begin
        count_inc = count_reg + COUNT_WIDTH'(1);
        if (count_reg == '0)
        begin
            min_next = sample;
            max_next = sample;
        end
        else
        begin
            min_next = (sample < min_reg) ? sample : min_reg;
            max_next = (sample > max_reg) ? sample : max_reg;
        end
        close      = (LW'(count_inc) >= limit) || end_of_range;
        count_next = close ? '0 : count_inc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= '0;
            max_reg   <= '0;
            count_reg <= '0;
        end
        else if (in_fire)
        begin
            min_reg   <= min_next;
            max_reg   <= max_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        res_ctrl.valid      = in_fire && close;
        res_ctrl.final_pair = end_of_range;
        peak_min            = min_next;
        peak_max            = max_next;
    end

endmodule

/* sv/mmpd_out_buf.sv */
// mmpd_out_buf: result register with a skid stage behind it
// standalone, no package dependency
module mmpd_out_buf #(
    parameter int unsigned DW = 33
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] in_data,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [DW-1:0] out_data
);

    logic          out_valid_reg;
    logic          out_valid_next;
    logic [DW-1:0] out_data_reg;
    logic [DW-1:0] out_data_next;
    logic          skid_valid_reg;
    logic          skid_valid_next;
    logic [DW-1:0] skid_data_reg;
    logic [DW-1:0] skid_data_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_valid;
                out_data_next  = in_data;
            end
        end
        else if (in_valid && !skid_valid_reg)
        begin
            // output stalled: park the new item in the skid stage
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* sv/min_max_peak_decimator.sv */
// min_max_peak_decimator: the min/max pair of an accepted sample that closes
// a window is registered in the output buffer before it reaches the output port
// throughput one sample per cycle while the skid is empty, set by the single
// compare/update stage; a two-entry output register (result plus skid) absorbs
// one more result while the output stalls; a full skid holds the input until it drains
// rst_n clears the window (empty), the output buffer and sets samples_per_peak to 1
module min_max_peak_decimator #(
    parameter int unsigned SAMPLE_WIDTH = 16,
    parameter int unsigned COUNT_WIDTH  = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [mmpd_pkg::CFG_WIDTH-1:0]          cfg_data,   // samples_per_peak
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [8*((SAMPLE_WIDTH+7)/8)-1:0]       s_tdata,    // sample
    input  logic                                    s_tlast,    // end_of_range
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [8*((2*SAMPLE_WIDTH+7)/8)-1:0]     m_tdata,    // peak_min, peak_max
    output logic                                    m_tlast     // final_pair
);

    localparam int unsigned OUT_TW = 8 * ((2 * SAMPLE_WIDTH + 7) / 8);
    localparam int unsigned DW     = 2 * SAMPLE_WIDTH + 1;

    logic [mmpd_pkg::CFG_WIDTH-1:0] spp_reg;
    logic                           in_fire;
    mmpd_pkg::res_ctrl_t            res_ctrl;
    logic signed [SAMPLE_WIDTH-1:0] peak_min;
    logic signed [SAMPLE_WIDTH-1:0] peak_max;
    logic [DW-1:0]                  res_data;
    logic [DW-1:0]                  out_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spp_reg <= mmpd_pkg::CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            spp_reg <= cfg_data;
        end
    end

    assign in_fire = s_tvalid && s_tready;

    mmpd_window #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_window (
        .clk              (clk),
        .rst_n            (rst_n),
        .samples_per_peak (spp_reg),
        .in_fire          (in_fire),
        .sample           (s_tdata[SAMPLE_WIDTH-1:0]),
        .end_of_range     (s_tlast),
        .res_ctrl         (res_ctrl),
        .peak_min         (peak_min),
        .peak_max         (peak_max)
    );

    assign res_data = {res_ctrl.final_pair, peak_max, peak_min};

    mmpd_out_buf #(
        .DW (DW)
    ) u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_ctrl.valid),
        .in_data   (res_data),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = OUT_TW'(out_data[2*SAMPLE_WIDTH-1:0]);
    assign m_tlast = out_data[DW-1];

endmodule

/* sv/mmpd_checker.sv */
// mmpd_checker: port-level assertions for min_max_peak_decimator
// bound to the top level below; uses mmpd_pkg for the config width
module mmpd_checker #(
    parameter int unsigned SAMPLE_WIDTH = 16,
    parameter int unsigned COUNT_WIDTH  = 16
) (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    cfg_valid,
    input logic                                    cfg_ready,
    input logic [mmpd_pkg::CFG_WIDTH-1:0]          cfg_data,
    input logic                                    s_tvalid,
    input logic                                    s_tready,
    input logic [8*((SAMPLE_WIDTH+7)/8)-1:0]       s_tdata,
    input logic                                    s_tlast,
    input logic                                    m_tvalid,
    input logic                                    m_tready,
    input logic [8*((2*SAMPLE_WIDTH+7)/8)-1:0]     m_tdata,
    input logic                                    m_tlast
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // after an accepted range end the output always holds a result on the next cycle
    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result after end of range");

    // input only backs up when the output holds a result
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

endmodule

bind min_max_peak_decimator mmpd_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
) u_mmpd_checker (.*);

/* tb/min_max_peak_decimator_test.sv */
// min_max_peak_decimator_test: self-checking testbench for the min/max peak decimator
// drives samples and window lengths, predicts or takes from directed rows every min/max pair, compares at the output
// depends on mmpd_pkg and min_max_peak_decimator
module min_max_peak_decimator_test;

    localparam int SW = 16;
    localparam int CW = mmpd_pkg::CFG_WIDTH;
    // largest value the window counter can hold
    localparam int unsigned COUNT_TOP = 65535;
    localparam int STALL_LIMIT = 200;

    typedef struct {
        logic signed [SW-1:0] lo;
        logic signed [SW-1:0] hi;
        bit                   fin;
    } peak_pair_t;

    typedef enum bit {ROW_SETUP, ROW_SAMPLE} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [15:0] value;
        bit          last;
        bit          typed;
        peak_pair_t  want;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CW-1:0]        cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata = '0;   // sample
    logic                 s_tlast = 1'b0; // end_of_range
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [31:0]          m_tdata;        // peak_min, peak_max
    logic                 m_tlast;        // final_pair

    // predictor state
    logic [CW-1:0]        peak_len;
    logic signed [SW-1:0] win_lo;
    logic signed [SW-1:0] win_hi;
    logic [15:0]          win_count;

    peak_pair_t pending_pairs[$];
    dir_row_t   dir_rows[$];
    bit         failed = 1'b0;
    bit         tx_calm = 1'b0;
    bit         rx_calm = 1'b0;
    int         rx_wait = 0;
    int         idle_cycles = 0;

    min_max_peak_decimator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // fold one sample into the window, returns 1 when a pair closes
    function automatic bit fold_sample(input logic signed [SW-1:0] s, input bit last,
                                       output peak_pair_t p);
        int unsigned lim;
        lim = peak_len;
        if (lim == 0)
            lim = 1;
        if (lim > COUNT_TOP)
            lim = COUNT_TOP;
        if (win_count == 0)
        begin
            win_lo = s;
            win_hi = s;
        end
        else
        begin
            if (s > win_hi)
                win_hi = s;
            if (s < win_lo)
                win_lo = s;
        end
        win_count = win_count + 1'b1;
        p.lo  = win_lo;
        p.hi  = win_hi;
        p.fin = last;
        if (win_count >= lim || last)
        begin
            win_count = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic send_sample(input logic signed [SW-1:0] s, input bit last, input bit typed,
                               input peak_pair_t want);
        int         gap;
        bit         closes;
        peak_pair_t p;
        gap = tx_calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        closes = fold_sample(s, last, p);
        if (typed)
            pending_pairs = {pending_pairs, want};
        else if (closes)
            pending_pairs = {pending_pairs, p};
        if ($urandom_range(0, 31) == 0)
            tx_calm = !tx_calm;
    endtask

    // only written with the block drained and settled
    task automatic write_peak_len(input logic [CW-1:0] v);
        s_tvalid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        peak_len = v;
    endtask

    task automatic add_setup(input logic [15:0] v);
        dir_row_t r;
        r = '{ROW_SETUP, v, 1'b0, 1'b0, '{0, 0, 1'b0}};
        dir_rows = {dir_rows, r};
    endtask

    task automatic add_sample(input logic signed [SW-1:0] s, input bit last, input bit typed,
                              input logic signed [SW-1:0] lo, input logic signed [SW-1:0] hi,
                              input bit fin);
        dir_row_t r;
        r = '{ROW_SAMPLE, s, last, typed, '{lo, hi, fin}};
        dir_rows = {dir_rows, r};
    endtask

    // output side: check each accepted pair, then draw the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin : rx_side
            peak_pair_t exp_pair;
            if (m_tvalid && m_tready)
            begin
                if (pending_pairs.size() == 0)
                begin
                    $display("%0t unexpected pair: min %0d max %0d final %0b", $time,
                             $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tlast);
                    failed = 1'b1;
                end
                else
                begin
                    exp_pair = pending_pairs.pop_front();
                    if ($signed(m_tdata[15:0]) !== exp_pair.lo)
                    begin
                        $display("%0t peak_min mismatch: expected %0d, actual %0d", $time,
                                 exp_pair.lo, $signed(m_tdata[15:0]));
                        failed = 1'b1;
                    end
                    if ($signed(m_tdata[31:16]) !== exp_pair.hi)
                    begin
                        $display("%0t peak_max mismatch: expected %0d, actual %0d", $time,
                                 exp_pair.hi, $signed(m_tdata[31:16]));
                        failed = 1'b1;
                    end
                    if (m_tlast !== exp_pair.fin)
                    begin
                        $display("%0t final_pair mismatch: expected %0b, actual %0b", $time,
                                 exp_pair.fin, m_tlast);
                        failed = 1'b1;
                    end
                end
                rx_wait = rx_calm ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 15) == 0)
                    rx_calm = !rx_calm;
            end
            if (rx_wait > 0)
            begin
                m_tready <= 1'b0;
                rx_wait = rx_wait - 1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog on cycles where no item moves anywhere
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned    ph_len[10]   = '{1, 2, 0, 4, 7, 16, 3, 300, 65535, 0};
        int unsigned    ph_items[10] = '{150, 150, 100, 150, 150, 200, 150, 550, 150, 150};
        int unsigned    ph_den[10]   = '{8, 8, 8, 16, 16, 32, 4, 1000, 10, 16};
        peak_pair_t     no_pair;
        logic signed [SW-1:0] s;
        logic [CW-1:0]  len;
        no_pair = '{0, 0, 1'b0};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        peak_len  = mmpd_pkg::CFG_RESET;
        win_lo    = '0;
        win_hi    = '0;
        win_count = '0;
        @(posedge clk);

        // one sample per pair out of reset
        add_sample(32767, 1'b0, 1'b1, 32767, 32767, 1'b0);
        add_sample(-32768, 1'b0, 1'b1, -32768, -32768, 1'b0);
        add_sample(0, 1'b1, 1'b1, 0, 0, 1'b1);
        add_sample(-1, 1'b0, 1'b1, -1, -1, 1'b0);
        add_sample(21845, 1'b1, 1'b1, 21845, 21845, 1'b1);
        add_sample(-21846, 1'b0, 1'b1, -21846, -21846, 1'b0);
        // zero length acts as one
        add_setup(16'd0);
        add_sample(123, 1'b0, 1'b1, 123, 123, 1'b0);
        add_sample(-5, 1'b1, 1'b1, -5, -5, 1'b1);
        // full windows, early close, full window and range end together
        add_setup(16'd3);
        add_sample(100, 1'b0, 1'b0, 0, 0, 1'b0);
        add_sample(-32768, 1'b0, 1'b0, 0, 0, 1'b0);
        add_sample(32767, 1'b0, 1'b0, 0, 0, 1'b0);
        add_sample(5, 1'b0, 1'b0, 0, 0, 1'b0);
        add_sample(7, 1'b1, 1'b0, 0, 0, 1'b0);
        add_sample(1, 1'b0, 1'b0, 0, 0, 1'b0);
        add_sample(2, 1'b0, 1'b0, 0, 0, 1'b0);
        add_sample(3, 1'b1, 1'b0, 0, 0, 1'b0);
        // longest window, closed by range end only
        add_setup(16'hFFFF);
        add_sample(-32768, 1'b0, 1'b0, 0, 0, 1'b0);
        add_sample(32767, 1'b0, 1'b0, 0, 0, 1'b0);
        add_sample(0, 1'b1, 1'b0, 0, 0, 1'b0);
        add_sample(42, 1'b1, 1'b0, 0, 0, 1'b0);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_SETUP)
                write_peak_len(dir_rows[i].value);
            else
                send_sample(dir_rows[i].value, dir_rows[i].last, dir_rows[i].typed,
                            dir_rows[i].want);
        end

        for (int ph = 0; ph < 10; ph++)
        begin
            len = (ph == 9) ? CW'($urandom_range(1, 40)) : CW'(ph_len[ph]);
            write_peak_len(len);
            for (int k = 0; k < ph_items[ph]; k++)
            begin
                case ($urandom_range(0, 9))
                    0: s = -32768;
                    1: s = 32767;
                    2: s = SW'($urandom_range(0, 15) - 8);
                    default: s = SW'($urandom());
                endcase
                send_sample(s, $urandom_range(0, ph_den[ph] - 1) == 0, 1'b0, no_pair);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (!failed && pending_pairs.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
sv/mmpd_pkg.sv
sv/mmpd_window.sv
sv/mmpd_out_buf.sv
sv/min_max_peak_decimator.sv
sv/mmpd_checker.sv
tb/min_max_peak_decimator_test.sv
